// ===== design/lifo_stack_command_engine_core_defines.svh =====
// ---------------------------------------------------------------------------
// lifo stack command engine - assertion macros
// concurrent check helpers shared by the engine rtl
// ---------------------------------------------------------------------------
`ifndef LIFO_STACK_COMMAND_ENGINE_CORE_DEFINES_SVH
`define LIFO_STACK_COMMAND_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define LSCE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LSCE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lsce_pkg.sv =====
// ---------------------------------------------------------------------------
// lsce_pkg
// shared constants, codes and types of the lifo stack command engine
// ---------------------------------------------------------------------------
package lsce_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int VALUE_WIDTH = 16;

   // fixed beat field widths
   localparam int REQ_TYPE_W  = 3;
   localparam int VAL_FIELD_W = 16;
   localparam int POP_CNT_W   = 7;
   localparam int OCC_W       = 7;
   localparam int STATUS_W    = 2;

   // stored width: values are cut to the field and to VALUE_WIDTH
   localparam int STORE_W = (VALUE_WIDTH < VAL_FIELD_W) ? VALUE_WIDTH : VAL_FIELD_W;
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUSH  = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_POP   = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COUNT = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_PEEK  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_DRAIN = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // shift control for the cell chain
   typedef struct packed {
      logic push;
      logic pop;
   } lsce_shift_type;

   // result beat payload
   typedef struct packed {
      logic [VAL_FIELD_W-1:0] out_value;
      logic                   value_valid;
      logic [OCC_W-1:0]       occupancy;
      logic [STATUS_W-1:0]    status;
      logic                   last;
   } lsce_rsp_type;

endpackage

// ===== design/lsce_req_if.sv =====
// ---------------------------------------------------------------------------
// lsce_req_if
// command channel: valid/ready plus the command fields
// ---------------------------------------------------------------------------
interface lsce_req_if import lsce_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [VAL_FIELD_W-1:0] push_value;
   logic [POP_CNT_W-1:0]   pop_count;

   modport source (output valid, output req_type, output push_value, output pop_count,
                   input ready);
   modport sink   (input valid, input req_type, input push_value, input pop_count,
                   output ready);
endinterface

// ===== design/lsce_rsp_if.sv =====
// ---------------------------------------------------------------------------
// lsce_rsp_if
// result channel: valid/ready plus the result fields
// ---------------------------------------------------------------------------
interface lsce_rsp_if import lsce_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [VAL_FIELD_W-1:0] out_value;
   logic                   value_valid;
   logic [OCC_W-1:0]       occupancy;
   logic [STATUS_W-1:0]    status;
   logic                   last;

   modport source (output valid, output out_value, output value_valid, output occupancy,
                   output status, output last, input ready);
   modport sink   (input valid, input out_value, input value_valid, input occupancy,
                   input status, input last, output ready);
endinterface

// ===== design/lsce_cell.sv =====
// ---------------------------------------------------------------------------
// lsce_cell
// one stack slot: loads from the slot above on push, from below on pop
// ---------------------------------------------------------------------------
module lsce_cell import lsce_pkg::*; (
   input  logic               clock,
   input  lsce_shift_type     shift,
   input  logic [STORE_W-1:0] from_above,
   input  logic [STORE_W-1:0] from_below,
   output logic [STORE_W-1:0] data
);

   logic [STORE_W-1:0] data_ff;
   logic [STORE_W-1:0] data_in;

   always_comb begin
      if (shift.push) begin
         data_in = from_above;
      end else if (shift.pop) begin
         data_in = from_below;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/lsce_chain.sv =====
// ---------------------------------------------------------------------------
// lsce_chain
// row of stack cells, slot 0 is the top of stack
// ---------------------------------------------------------------------------
module lsce_chain import lsce_pkg::*; (
   input  logic               clock,
   input  lsce_shift_type     shift,
   input  logic [STORE_W-1:0] push_data,
   output logic [STORE_W-1:0] top_value
);

   logic [STORE_W-1:0] cell_data  [STACK_DEPTH];
   logic [STORE_W-1:0] cell_above [STACK_DEPTH];
   logic [STORE_W-1:0] cell_below [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_above[i] = push_data;
      end else begin : g_body
         assign cell_above[i] = cell_data[i-1];
      end
      // bottom slot keeps its own value on pop; it is dead once popped
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign cell_below[i] = cell_data[i];
      end else begin : g_link
         assign cell_below[i] = cell_data[i+1];
      end

      lsce_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (cell_above[i]),
         .from_below (cell_below[i]),
         .data       (cell_data[i])
      );
   end

   assign top_value = cell_data[0];

endmodule

// ===== design/lifo_stack_command_engine_core.sv =====
// ---------------------------------------------------------------------------
// lifo_stack_command_engine_core
// lifo stack engine: push, pop-n, count, peek and drain over a shift chain
// ---------------------------------------------------------------------------
//
//   channel   dir  beat contents
//   req_bus   in   req_type, push_value, pop_count
//   rsp_bus   out  out_value, value_valid, occupancy, status, last
//
// push, count and peek are handled on acceptance; pop n and drain then emit
// one result beat per cycle from the top cell while the output is not stalled
// the stack lives in a row of shift cells, so a push or a pop moves every
// entry one slot at once and the top is always in slot 0
// synchronous reset empties the stack; cell contents are not cleared
// a stalled result beat holds in the output register; a command is taken
// whenever the engine is idle and that register is empty or being drained
// ---------------------------------------------------------------------------
`include "lifo_stack_command_engine_core_defines.svh"

module lifo_stack_command_engine_core import lsce_pkg::*; (
   input logic   clock,
   input logic   reset,
   lsce_req_if.sink   req_bus,
   lsce_rsp_if.source rsp_bus
);

   // engine states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff,     state_in;
   logic [CNT_W-1:0] count_ff,     count_in;    // stored entries
   logic [CNT_W-1:0] rem_ff,       rem_in;      // beats left in a pop or drain run
   logic             rsp_valid_ff, rsp_valid_in;
   lsce_rsp_type     rsp_ff,       rsp_in;

   lsce_shift_type     shift;
   logic [STORE_W-1:0] push_data;
   logic [STORE_W-1:0] top_value;

   logic                   out_free;
   logic                   accept;
   logic                   stack_full;
   logic                   stack_empty;
   logic [POP_CNT_W-1:0]   count_wide;
   logic [VAL_FIELD_W-1:0] top_wide;

   // storage row
   lsce_chain u_chain (
      .clock     (clock),
      .shift     (shift),
      .push_data (push_data),
      .top_value (top_value)
   );

   // output register is free when empty or its beat leaves this cycle
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = (state_ff == ST_IDLE) && out_free;
   assign accept         = req_bus.valid && req_bus.ready;

   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign count_wide  = POP_CNT_W'(count_ff);
   assign top_wide    = VAL_FIELD_W'(top_value);
   assign push_data   = STORE_W'(req_bus.push_value);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      shift        = '0;

      if (accept) begin
         // default result shape for a single status beat
         rsp_in.out_value   = '0;
         rsp_in.value_valid = 1'b0;
         rsp_in.occupancy   = OCC_W'(count_ff);
         rsp_in.status      = ST_OK;
         rsp_in.last        = 1'b1;
         case (req_bus.req_type)
            REQ_PUSH: begin
               if (stack_full) begin
                  // dropped value, report full
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_FULL;
               end else begin
                  shift.push = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            REQ_POP: begin
               if (req_bus.pop_count > count_wide) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_SHORT;
               end else if (req_bus.pop_count == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  // pop_count fits the counter since it is within occupancy
                  state_in = ST_RUN;
                  rem_in   = CNT_W'(req_bus.pop_count);
               end
            end
            REQ_COUNT: begin
               rsp_valid_in = 1'b1;
            end
            REQ_PEEK: begin
               rsp_valid_in = 1'b1;
               if (stack_empty) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.out_value   = top_wide;
                  rsp_in.value_valid = 1'b1;
               end
            end
            REQ_DRAIN: begin
               if (stack_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_EMPTY;
               end else begin
                  state_in = ST_RUN;
                  rem_in   = count_ff;
               end
            end
            default: begin
               // unknown command: no beat, no state change
            end
         endcase
      end else if (state_ff == ST_RUN && out_free) begin
         // one popped entry per cycle while the output register is free, top first
         rsp_valid_in       = 1'b1;
         rsp_in.out_value   = top_wide;
         rsp_in.value_valid = 1'b1;
         rsp_in.occupancy   = OCC_W'(count_ff - 1'b1);
         rsp_in.status      = ST_OK;
         rsp_in.last        = (rem_ff == CNT_W'(1));
         shift.pop          = 1'b1;
         count_in           = count_ff - 1'b1;
         rem_in             = rem_ff - 1'b1;
         if (rem_ff == CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_value   = rsp_ff.out_value;
   assign rsp_bus.value_valid = rsp_ff.value_valid;
   assign rsp_bus.occupancy   = rsp_ff.occupancy;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.last        = rsp_ff.last;

   // occupancy never passes the stack depth
   `LSCE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(STACK_DEPTH), "occupancy above depth")

   // a run always has beats left and never more than stored entries
   `LSCE_ASSERT_IMP(a_run_rem, clock, reset, state_ff == ST_RUN, rem_ff != '0 && rem_ff <= count_ff, "bad run length")

   // no command taken mid-run
   `LSCE_ASSERT_IMP(a_run_no_accept, clock, reset, state_ff == ST_RUN, !req_bus.ready, "command taken during run")

   // every emitted run beat removes exactly one entry
   `LSCE_ASSERT_NXT(a_run_pop, clock, reset, state_ff == ST_RUN && out_free, count_ff == $past(count_ff) - 1'b1, "run beat did not pop")

endmodule
